// ----- hdl/mean_background_subtractor_top_assert.svh -----
// Assertion macros used by mbs_back of the mean background subtractor.
// Each macro expects signals named clock and reset in the including module.
`ifndef MEAN_BACKGROUND_SUBTRACTOR_TOP_ASSERT_SVH
`define MEAN_BACKGROUND_SUBTRACTOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define MBS_ASSERT_ALWAYS(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("mbs assertion failed");
`define MBS_ASSERT_IMPLIES(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mbs assertion failed");
`define MBS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mbs assertion failed");
`else
`define MBS_ASSERT_ALWAYS(name, cond)
`define MBS_ASSERT_IMPLIES(name, ante, cons)
`define MBS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- hdl/mbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the mean background subtractor.
// No dependencies.
package mbs_pkg;

   localparam int MAX_PIXELS = 65536;
   localparam int MAX_FRAMES = 1024;

   localparam int IDXF_W = 16;
   localparam int PIX_W = 8;
   localparam int REQ_W = 2;
   localparam int IDX_W = $clog2(MAX_PIXELS);
   localparam int SUM_W = 18;
   localparam int FC_W = 11;
   localparam int THR_W = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 11;
   localparam int DIV_W = $clog2(MAX_FRAMES) + 1;
   localparam int QB = 8;
   localparam int REM_W = DIV_W + QB;

   localparam int CQ_DEPTH = 4;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = CQ_PTR_W + 1;
   localparam int OQ_DEPTH = 16;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = OQ_PTR_W + 1;

   localparam logic [REQ_W-1:0] REQ_ACC = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CLS = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd1;

   localparam logic [PIX_W-1:0] GRAY_MAX = 8'd255;

   typedef enum logic [1:0] {
      OP_ACC,
      OP_CLS,
      OP_CLR
   } op_type;

   typedef struct packed {
      op_type            op;
      logic              zero;
      logic [IDX_W-1:0]  idx;
      logic [PIX_W-1:0]  pix;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_stat_type;

   typedef struct packed {
      logic              valid;
      logic [SUM_W-1:0]  sum;
      logic [PIX_W-1:0]  pix;
   } div_in_type;

   typedef struct packed {
      logic              valid;
      logic [PIX_W-1:0]  fg;
      logic [PIX_W-1:0]  bg;
   } div_res_type;

   function automatic logic [DIV_W-1:0] div_clamp(input logic [FC_W-1:0] fc);
      logic [DIV_W-1:0] d;
      if (fc == '0) begin
         d = DIV_W'(1);
      end else if (fc > FC_W'(MAX_FRAMES)) begin
         d = DIV_W'(MAX_FRAMES);
      end else begin
         d = DIV_W'(fc);
      end
      return d;
   endfunction

endpackage

// ----- hdl/mean_background_subtractor_top.sv -----
`timescale 1ns / 1ps
// Top level of the mean background subtractor: front end, back end and their wiring.
// Depends on mbs_pkg, mbs_front and mbs_back.
//
//   Channel   Direction   Handshake            Payload
//   req       in          req_valid/req_stall  req_type, req_pixel_index, req_pixel_value
//   rsp       out         rsp_valid/rsp_stall  rsp_foreground, rsp_background
//   csr       in          csr_we               csr_index, csr_wdata
//
// One request is accepted per cycle while req_stall is low.
// The accumulator memory does one read and one write per cycle, and the divider is
// pipelined one quotient bit per stage, so both sustain one item per clock while issue is not held.
// After reset a clearing pass zeroes the 65536 accumulators, one per cycle, with
// req_stall held high until the pass ends; configuration writes are taken throughout.
// A full command queue holds req_stall high; a full result queue halts command issue.
module mean_background_subtractor_top
   import mbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [REQ_W-1:0]       req_type,
   input  logic [IDXF_W-1:0]      req_pixel_index,
   input  logic [PIX_W-1:0]       req_pixel_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIX_W-1:0]       rsp_foreground,
   output logic [PIX_W-1:0]       rsp_background,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   back_stat_type stat;
   logic          cmd_valid;
   cmd_type       cmd;

   mbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_pixel_index (req_pixel_index),
      .req_pixel_value (req_pixel_value),
      .stat            (stat),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd)
   );

   mbs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .stat           (stat),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_foreground (rsp_foreground),
      .rsp_background (rsp_background)
   );

endmodule

// ----- hdl/mbs_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests, decodes and range-checks them, and queues commands.
// Depends on mbs_pkg.
module mbs_front
   import mbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [REQ_W-1:0]    req_type,
   input  logic [IDXF_W-1:0]   req_pixel_index,
   input  logic [PIX_W-1:0]    req_pixel_value,
   input  back_stat_type       stat,
   output logic                cmd_valid,
   output cmd_type             cmd
);

   cmd_type                q_mem_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]    wr_ff, wr_in;
   logic [CQ_PTR_W-1:0]    rd_ff, rd_in;
   logic [CQ_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                   accept;
   logic                   in_range;
   logic                   keep;
   logic                   push;
   cmd_type                dec;

   assign req_stall = stat.clearing || (cnt_ff == CQ_CNT_W'(CQ_DEPTH));
   assign accept = req_valid && !req_stall;
   assign in_range = {1'b0, req_pixel_index} < (IDXF_W + 1)'(MAX_PIXELS);

   always_comb begin
      dec.op = OP_ACC;
      dec.zero = !in_range;
      dec.idx = req_pixel_index[IDX_W-1:0];
      dec.pix = req_pixel_value;
      keep = 1'b0;
      case (req_type)
         REQ_ACC: begin
            dec.op = OP_ACC;
            keep = in_range;
         end
         REQ_CLS: begin
            dec.op = OP_CLS;
            keep = 1'b1;
         end
         REQ_CLR: begin
            dec.op = OP_CLR;
            keep = in_range;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = accept && keep;
   assign cmd_valid = cnt_ff != '0;
   assign cmd = q_mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = stat.pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !stat.pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && stat.pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ff] <= dec;
      end
   end

endmodule

// ----- hdl/mbs_div.sv -----
`timescale 1ns / 1ps
// Pipelined divider that turns a pixel sum into the background level and foreground value.
// One quotient bit per stage; depends on mbs_pkg.
module mbs_div
   import mbs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_in_type          din,
   input  logic [DIV_W-1:0]    dvs,
   input  logic [THR_W-1:0]    thr,
   output div_res_type         res
);

   logic [REM_W-1:0]   rem_ff [QB+1];
   logic [QB-1:0]      q_ff   [QB+1];
   logic [PIX_W-1:0]   pix_ff [QB+1];
   logic               big_ff [QB+1];
   logic               v_ff   [QB+1];
   logic [REM_W-1:0]   top_dvs;
   div_res_type        res_ff, res_in;
   logic [PIX_W-1:0]   bg;
   logic [PIX_W-1:0]   diff;

   assign top_dvs = REM_W'(dvs) << QB;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= din.valid;
      end
      rem_ff[0] <= REM_W'(din.sum);
      q_ff[0] <= '0;
      pix_ff[0] <= din.pix;
      big_ff[0] <= REM_W'(din.sum) >= top_dvs;
   end

   for (genvar j = 1; j <= QB; j++) begin : g_step
      logic [REM_W-1:0] dsh;
      logic             ge;

      assign dsh = REM_W'(dvs) << (QB - j);
      assign ge = rem_ff[j-1] >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_ff[j-1];
         end
         rem_ff[j] <= ge ? rem_ff[j-1] - dsh : rem_ff[j-1];
         q_ff[j] <= {q_ff[j-1][QB-2:0], ge};
         pix_ff[j] <= pix_ff[j-1];
         big_ff[j] <= big_ff[j-1];
      end
   end

   always_comb begin
      bg = big_ff[QB] ? GRAY_MAX : q_ff[QB];
      diff = (bg >= pix_ff[QB]) ? bg - pix_ff[QB] : pix_ff[QB] - bg;
      res_in.valid = v_ff[QB];
      res_in.bg = bg;
      res_in.fg = ({1'b0, diff} < thr) ? '0 : diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= res_in.valid;
      end
      res_ff.fg <= res_in.fg;
      res_ff.bg <= res_in.bg;
   end

   assign res = res_ff;

endmodule

// ----- hdl/mbs_back.sv -----
`timescale 1ns / 1ps
// Back end: accumulator memory with clearing pass, read-modify-write, divider and result queue.
// Depends on mbs_pkg, mbs_div and the assertion macro header.
`include "mean_background_subtractor_top_assert.svh"
module mbs_back
   import mbs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  cmd_type                cmd,
   output back_stat_type          stat,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIX_W-1:0]       rsp_foreground,
   output logic [PIX_W-1:0]       rsp_background
);

   logic [SUM_W-1:0]    mem [MAX_PIXELS];
   logic [SUM_W-1:0]    rd_ff;
   logic                clearing_ff;
   logic [IDX_W-1:0]    clr_ff;
   logic [FC_W-1:0]     fc_ff;
   logic [THR_W-1:0]    thr_ff;

   logic                v1_ff;
   op_type              op1_ff;
   logic [IDX_W-1:0]    a1_ff;
   logic [PIX_W-1:0]    pix1_ff;
   logic                z1_ff;
   logic                fwd_ff, fwd_in;
   logic [SUM_W-1:0]    fwdd_ff;

   logic                issue;
   logic [SUM_W-1:0]    cur;
   logic [SUM_W:0]      acc;
   logic [SUM_W-1:0]    new_sum;
   logic                we;
   logic [IDX_W-1:0]    wa;
   logic [SUM_W-1:0]    wd;
   div_in_type          din;
   div_res_type         dres;

   div_res_type         oq_mem_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] owr_ff;
   logic [OQ_PTR_W-1:0] ord_ff;
   logic [OQ_CNT_W-1:0] ocnt_ff, ocnt_in;
   logic [OQ_CNT_W-1:0] res_ff, res_in;
   logic                opop;
   logic                cls_issue;

   // Each issued classify holds a result queue slot, so nothing stalls after issue.
   assign issue = cmd_valid && !clearing_ff && (res_ff < OQ_CNT_W'(OQ_DEPTH));
   assign cls_issue = issue && (cmd.op == OP_CLS);
   assign stat.pop = issue;
   assign stat.clearing = clearing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= FC_W'(1);
         thr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_COUNT: fc_ff <= csr_wdata[FC_W-1:0];
            CSR_THRESHOLD: thr_ff <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == IDX_W'(MAX_PIXELS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      cur = fwd_ff ? fwdd_ff : rd_ff;
      acc = {1'b0, cur} + (SUM_W + 1)'(pix1_ff);
      new_sum = '0;
      case (op1_ff)
         OP_ACC: new_sum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
         OP_CLR: new_sum = '0;
         default: new_sum = cur;
      endcase
      we = clearing_ff || (v1_ff && (op1_ff != OP_CLS));
      wa = clearing_ff ? clr_ff : a1_ff;
      wd = clearing_ff ? '0 : new_sum;
      fwd_in = issue && v1_ff && (op1_ff != OP_CLS) && (a1_ff == cmd.idx);
      din.valid = v1_ff && (op1_ff == OP_CLS);
      din.sum = z1_ff ? '0 : cur;
      din.pix = pix1_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[cmd.idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         fwd_ff <= fwd_in;
      end
      op1_ff <= cmd.op;
      a1_ff <= cmd.idx;
      pix1_ff <= cmd.pix;
      z1_ff <= cmd.zero;
      fwdd_ff <= new_sum;
   end

   mbs_div u_div (
      .clock (clock),
      .reset (reset),
      .din   (din),
      .dvs   (div_clamp(fc_ff)),
      .thr   (thr_ff),
      .res   (dres)
   );

   assign rsp_valid = ocnt_ff != '0;
   assign opop = rsp_valid && !rsp_stall;
   assign rsp_foreground = oq_mem_ff[ord_ff].fg;
   assign rsp_background = oq_mem_ff[ord_ff].bg;

   always_comb begin
      ocnt_in = ocnt_ff;
      if (dres.valid && !opop) begin
         ocnt_in = ocnt_ff + 1'b1;
      end else if (!dres.valid && opop) begin
         ocnt_in = ocnt_ff - 1'b1;
      end
      res_in = res_ff;
      if (cls_issue && !opop) begin
         res_in = res_ff + 1'b1;
      end else if (!cls_issue && opop) begin
         res_in = res_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff <= '0;
         ord_ff <= '0;
         ocnt_ff <= '0;
         res_ff <= '0;
      end else begin
         if (dres.valid) begin
            owr_ff <= owr_ff + 1'b1;
         end
         if (opop) begin
            ord_ff <= ord_ff + 1'b1;
         end
         ocnt_ff <= ocnt_in;
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dres.valid) begin
         oq_mem_ff[owr_ff] <= dres;
      end
   end

   `MBS_ASSERT_ALWAYS(a_res_bound, res_ff <= OQ_CNT_W'(OQ_DEPTH))
   `MBS_ASSERT_ALWAYS(a_queue_within_res, ocnt_ff <= res_ff)
   `MBS_ASSERT_IMPLIES(a_room_on_push, dres.valid, ocnt_ff < OQ_CNT_W'(OQ_DEPTH))
   `MBS_ASSERT_NEXT(a_no_issue_while_clearing, clearing_ff, !v1_ff)

endmodule
